FILE: src/d2d_pkg.sv
// d2d_pkg: shared constants, types and register codes for the disparity to depth core.
// Used by every module in src; depends on nothing.

package d2d_pkg;

   // Fixed field widths
   localparam int WORD_W        = 16;
   localparam int DISP_W        = 12;
   localparam int FBP_W         = 24;
   localparam int FRACTION_BITS = 5;
   localparam int DEPTH_WIDTH   = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = FBP_W;

   // Divider shape: numerator is fbp scaled by the fraction bits
   localparam int NUM_W           = FBP_W + FRACTION_BITS;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (DEPTH_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int QUO_W           = DIV_STAGES * STEPS_PER_STAGE;
   localparam int NUMX_W          = NUM_W + QUO_W;

   // Front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Threshold reset: 4.0 in the fixed-point disparity format
   localparam logic [DISP_W-1:0] MIN_DISP_RESET = DISP_W'(4 << FRACTION_BITS);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_BASELINE = 2'd0,
      CSR_MIN_DISPARITY  = 2'd1
   } csr_index_type;

   // One classified item between front and back
   typedef struct packed {
      logic [DISP_W-1:0] raw;
      logic              pass;
   } entry_type;

endpackage

FILE: src/d2d_front.sv
// d2d_front: input register that takes disparity words and classifies them
// against the threshold. Depends on d2d_pkg.

module d2d_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [d2d_pkg::WORD_W-1:0]    req_disparity_word,
   input  logic [d2d_pkg::DISP_W-1:0]    min_disparity_raw,
   input  logic                          queue_full,
   output logic                          push_valid,
   output d2d_pkg::entry_type            push_entry
);

   logic                front_valid_ff;
   logic                front_valid_in;
   d2d_pkg::entry_type  front_entry_ff;
   d2d_pkg::entry_type  front_entry_in;
   logic                accept;
   logic [d2d_pkg::DISP_W-1:0] raw;

   // Hold only while the queue refuses our item
   assign req_stall = front_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   // Classify: top word bits dropped, strict compare with threshold
   assign raw                 = req_disparity_word[d2d_pkg::DISP_W-1:0];
   assign front_entry_in.raw  = raw;
   assign front_entry_in.pass = (raw > min_disparity_raw);

   assign front_valid_in = accept || (front_valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_entry_ff <= front_entry_in;
      end
   end

   assign push_valid = front_valid_ff;
   assign push_entry = front_entry_ff;

endmodule

FILE: src/d2d_queue.sv
// d2d_queue: small FIFO of classified items between front and back.
// Depends on d2d_pkg.

module d2d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  d2d_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output d2d_pkg::entry_type  pop_entry
);

   d2d_pkg::entry_type                  slot_ff [d2d_pkg::QUEUE_DEPTH];
   logic [d2d_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [d2d_pkg::QUEUE_PTR_W-1:0]     wr_ptr_in;
   logic [d2d_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [d2d_pkg::QUEUE_PTR_W-1:0]     rd_ptr_in;
   logic [d2d_pkg::QUEUE_CNT_W-1:0]     count_ff;
   logic [d2d_pkg::QUEUE_CNT_W-1:0]     count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full    = (count_ff == d2d_pkg::QUEUE_CNT_W'(d2d_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = slot_ff[rd_ptr_ff];

endmodule

FILE: src/d2d_back.sv
// d2d_back: pipelined restoring divider with saturation check and output register.
// Two quotient bits per stage. Depends on d2d_pkg.

module d2d_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               queue_empty,
   input  d2d_pkg::entry_type                 queue_entry,
   output logic                               queue_pop,
   input  logic [d2d_pkg::FBP_W-1:0]          focal_baseline_product,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [d2d_pkg::DEPTH_WIDTH-1:0]    rsp_depth_value,
   output logic                               rsp_depth_valid
);

   typedef struct packed {
      logic [d2d_pkg::DISP_W-1:0] raw;
      logic                       pass;
      logic                       sat;
      logic [d2d_pkg::DISP_W-1:0] rem;
      logic [d2d_pkg::QUO_W-1:0]  quo;
   } div_stage_type;

   // One stage: shift in numerator bits, trial subtract, shift quotient bits in
   function automatic div_stage_type div_stage(input div_stage_type s);
      div_stage_type            r;
      logic [d2d_pkg::DISP_W:0] rem_ext;
      r = s;
      for (int i = 0; i < d2d_pkg::STEPS_PER_STAGE; i++) begin
         rem_ext = {r.rem, r.quo[d2d_pkg::QUO_W-1]};
         r.quo   = {r.quo[d2d_pkg::QUO_W-2:0], 1'b0};
         if (rem_ext >= {1'b0, r.raw}) begin
            rem_ext  = rem_ext - {1'b0, r.raw};
            r.quo[0] = 1'b1;
         end
         r.rem = rem_ext[d2d_pkg::DISP_W-1:0];
      end
      return r;
   endfunction

   logic                                advance;
   logic [d2d_pkg::NUM_W-1:0]           num;
   logic [d2d_pkg::NUMX_W-1:0]          numx;
   logic [d2d_pkg::NUMX_W-1:0]          num_hi;
   logic [d2d_pkg::NUMX_W-1:0]          sat_hi;
   div_stage_type                       load_in;
   div_stage_type                       stage_ff    [d2d_pkg::DIV_STAGES + 1];
   logic                                stage_vld_ff[d2d_pkg::DIV_STAGES + 1];
   div_stage_type                       last;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [d2d_pkg::DEPTH_WIDTH-1:0]     rsp_depth_ff;
   logic [d2d_pkg::DEPTH_WIDTH-1:0]     rsp_depth_in;
   logic                                rsp_flag_ff;

   // Whole pipeline moves unless the output holds an untaken result
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign queue_pop = advance && !queue_empty;

   // Setup: scaled numerator, saturation test, initial partial remainder
   assign num    = d2d_pkg::NUM_W'(focal_baseline_product) << d2d_pkg::FRACTION_BITS;
   assign numx   = d2d_pkg::NUMX_W'(num);
   assign sat_hi = numx >> d2d_pkg::DEPTH_WIDTH;
   assign num_hi = numx >> d2d_pkg::QUO_W;

   always_comb begin
      load_in.raw  = queue_entry.raw;
      load_in.pass = queue_entry.pass;
      // quotient overflows iff num / 2^DEPTH_WIDTH >= raw
      load_in.sat  = (sat_hi >= d2d_pkg::NUMX_W'(queue_entry.raw));
      load_in.rem  = num_hi[d2d_pkg::DISP_W-1:0];
      load_in.quo  = numx[d2d_pkg::QUO_W-1:0];
   end

   // Stage 0 valid plus divide stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= d2d_pkg::DIV_STAGES; k++) begin
            stage_vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         stage_vld_ff[0] <= queue_pop;
         for (int k = 1; k <= d2d_pkg::DIV_STAGES; k++) begin
            stage_vld_ff[k] <= stage_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= load_in;
      end
   end

   // Divide stages
   for (genvar g = 1; g <= d2d_pkg::DIV_STAGES; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[g] <= div_stage(stage_ff[g-1]);
         end
      end
   end

   // Result select: zero when rejected, full scale on overflow
   assign last = stage_ff[d2d_pkg::DIV_STAGES];

   always_comb begin
      rsp_valid_in = advance ? stage_vld_ff[d2d_pkg::DIV_STAGES] : rsp_valid_ff;
      if (!last.pass) begin
         rsp_depth_in = '0;
      end else if (last.sat) begin
         rsp_depth_in = '1;
      end else begin
         rsp_depth_in = last.quo[d2d_pkg::DEPTH_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_depth_ff <= rsp_depth_in;
         rsp_flag_ff  <= last.pass;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_depth_value = rsp_depth_ff;
   assign rsp_depth_valid = rsp_flag_ff;

endmodule

FILE: src/disparity_to_depth_core.sv
// disparity_to_depth_core: one depth result per disparity word, one word per cycle while
// req_stall is low. Path from input transfer to result valid: front register, queue,
// setup stage, 8 divider stages of 2 quotient bits each, output register.
// Throughput is one transfer per cycle when rsp_stall is low; a stalled output freezes
// the divider pipeline and the 4-entry queue absorbs the front until it fills.
// Synchronous reset empties the pipeline and sets the registers to 0 and 4.0.

module disparity_to_depth_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [d2d_pkg::WORD_W-1:0]          req_disparity_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [d2d_pkg::DEPTH_WIDTH-1:0]     rsp_depth_value,
   output logic                                rsp_depth_valid,
   input  logic                                csr_write_enable,
   input  logic [d2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [d2d_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [d2d_pkg::FBP_W-1:0]   fbp_ff;
   logic [d2d_pkg::DISP_W-1:0]  min_disp_ff;
   logic                        push_valid;
   d2d_pkg::entry_type          push_entry;
   logic                        queue_full;
   logic                        queue_empty;
   logic                        queue_pop;
   d2d_pkg::entry_type          queue_entry;

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         fbp_ff      <= '0;
         min_disp_ff <= d2d_pkg::MIN_DISP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            d2d_pkg::CSR_FOCAL_BASELINE: fbp_ff      <= csr_write_data[d2d_pkg::FBP_W-1:0];
            d2d_pkg::CSR_MIN_DISPARITY:  min_disp_ff <= csr_write_data[d2d_pkg::DISP_W-1:0];
            default: ;
         endcase
      end
   end

   d2d_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_disparity_word (req_disparity_word),
      .min_disparity_raw  (min_disp_ff),
      .queue_full         (queue_full),
      .push_valid         (push_valid),
      .push_entry         (push_entry)
   );

   d2d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .pop_entry  (queue_entry)
   );

   d2d_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .queue_empty            (queue_empty),
      .queue_entry            (queue_entry),
      .queue_pop              (queue_pop),
      .focal_baseline_product (fbp_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_depth_value        (rsp_depth_value),
      .rsp_depth_valid        (rsp_depth_valid)
   );

endmodule
